@@ hw/rtl/sitda_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and character codes for the signed integer to decimal text converter.
package sitda_pkg;

  localparam int unsigned DigitW = 4;

  localparam logic [7:0] CharPad   = 8'd11;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;

  // Operation of one BCD digit cell in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_PAD,
    ST_SIGN,
    ST_DIGITS
  } state_e;

endpackage

@@ hw/rtl/sitda_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: number to convert and minimum field width.
interface sitda_in_if #(
  parameter int unsigned DataWidth = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] value;
  logic        [4:0]           min_width;

  modport source (output valid, output value, output min_width, input ready);
  modport sink   (input valid, input value, input min_width, output ready);
endinterface

@@ hw/rtl/sitda_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: one ASCII character per word, with end-of-run marker.
interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ hw/rtl/sitda_cell.sv @@
`timescale 1ns / 1ps
// One BCD digit cell: add-3 and shift during conversion, whole-digit shift during output.
module sitda_cell (
  input  logic                     clk_i,
  input  sitda_pkg::cell_mode_e    mode_i,
  input  logic                     bit_i,
  input  logic [sitda_pkg::DigitW-1:0] digit_i,
  output logic                     carry_o,
  output logic [sitda_pkg::DigitW-1:0] digit_o
);
  import sitda_pkg::*;

  logic [DigitW-1:0] digit_q, digit_d, adj;

  // Correct the digit before the doubling so it stays in BCD.
  assign adj     = (digit_q >= DigitW'(5)) ? digit_q + DigitW'(3) : digit_q;
  assign carry_o = adj[DigitW-1];
  assign digit_o = digit_q;

  always_comb begin
    unique case (mode_i)
      CELL_HOLD:   digit_d = digit_q;
      CELL_CLEAR:  digit_d = '0;
      CELL_DABBLE: digit_d = {adj[DigitW-2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text: after the word is taken, its magnitude is
// shifted with add-3 correction through a chain of BCD digit cells, then the top
// digit is checked and leading zero digits are dropped (up to 9 at 32 bits), then
// the characters (pads, sign, digits) are loaded into the output register at one
// per cycle while the sink keeps up; a new word is taken the cycle after the last
// character is loaded.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned MAX_WIDTH  = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sitda_in_if.sink    in_i,
  sitda_out_if.source out_o
);
  import sitda_pkg::*;

  // Digits needed for any DATA_WIDTH-bit magnitude.
  localparam int unsigned NDIG = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned NW   = $clog2(NDIG + 1);
  localparam int unsigned BW   = $clog2(DATA_WIDTH + 1);
  localparam int unsigned MW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW   = (MW > 5) ? MW : 5;

  state_e                state_q, state_d;
  cell_mode_e            mode;
  logic [DATA_WIDTH-1:0] mag_q, mag_d, raw;
  logic [BW-1:0]         bit_cnt_q, bit_cnt_d;
  logic [NW-1:0]         ndig_q, ndig_d;
  logic [CW-1:0]         pad_q, pad_d;
  logic [4:0]            minw_q, minw_d;
  logic                  neg_q, neg_d;
  logic                  ov_q, ov_d;
  logic [7:0]            ch_q, ch_d;
  logic                  last_q, last_d;
  logic                  emit;
  logic [CW-1:0]         lim, tlen, pads;

  logic [NDIG-1:0]        carry;
  logic [DigitW-1:0]      digit [NDIG];
  logic [DigitW-1:0]      top_digit;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic              bit_in;
    logic [DigitW-1:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = mag_q[DATA_WIDTH-1];
      assign digit_in = '0;
    end else begin : g_next
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end
    sitda_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_digit = digit[NDIG-1];
  assign raw       = DATA_WIDTH'(in_i.value);

  // Clamp the field width, then pad only what the text leaves over.
  assign lim  = (CW'(minw_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(minw_q);
  assign tlen = CW'(ndig_q) + CW'(neg_q);
  assign pads = (lim > tlen) ? lim - tlen : '0;

  assign emit         = !ov_q || out_o.ready;
  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid     = ov_q;
  assign out_o.character = ch_q;
  assign out_o.last      = last_q;

  always_comb begin
    state_d   = state_q;
    mode      = CELL_HOLD;
    mag_d     = mag_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    pad_d     = pad_q;
    minw_d    = minw_q;
    neg_d     = neg_q;
    ov_d      = ov_q && !out_o.ready;
    ch_d      = ch_q;
    last_d    = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          neg_d     = raw[DATA_WIDTH-1];
          mag_d     = raw[DATA_WIDTH-1] ? (~raw + DATA_WIDTH'(1)) : raw;
          minw_d    = in_i.min_width;
          bit_cnt_d = BW'(DATA_WIDTH);
          ndig_d    = NW'(NDIG);
          mode      = CELL_CLEAR;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        mode      = CELL_DABBLE;
        mag_d     = {mag_q[DATA_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BW'(1);
        if (bit_cnt_q == BW'(1)) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // Drop leading zero digits, keeping at least one.
        if (top_digit != '0 || ndig_q == NW'(1)) begin
          pad_d = pads;
          if (pads != '0) begin
            state_d = ST_PAD;
          end else if (neg_q) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_DIGITS;
          end
        end else begin
          mode   = CELL_SHIFT;
          ndig_d = ndig_q - NW'(1);
        end
      end
      ST_PAD: begin
        if (emit) begin
          ov_d   = 1'b1;
          ch_d   = CharPad;
          last_d = 1'b0;
          pad_d  = pad_q - CW'(1);
          if (pad_q == CW'(1)) begin
            state_d = neg_q ? ST_SIGN : ST_DIGITS;
          end
        end
      end
      ST_SIGN: begin
        if (emit) begin
          ov_d    = 1'b1;
          ch_d    = CharMinus;
          last_d  = 1'b0;
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (emit) begin
          ov_d   = 1'b1;
          ch_d   = CharZero + 8'(top_digit);
          last_d = (ndig_q == NW'(1));
          mode   = CELL_SHIFT;
          ndig_d = ndig_q - NW'(1);
          if (ndig_q == NW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bit_cnt_q <= bit_cnt_d;
    ndig_q    <= ndig_d;
    pad_q     <= pad_d;
    minw_q    <= minw_d;
    neg_q     <= neg_d;
    ch_q      <= ch_d;
    last_q    <= last_d;
  end

endmodule

@@ hw/rtl/sitda_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the decimal text converter, bound to its top level.
module sitda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_character_i,
  input logic       out_last_i
);
  import sitda_pkg::*;

  // Hold a stalled output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_character_i)
      && $stable(out_last_i))
    else $error("stalled output word changed");

  // Busy right after taking a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while converting");

  // When open for a new word, nothing but the final character may wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i || out_last_i)
    else $error("input open in the middle of a run");

  // Only pad, minus or digit codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_character_i == CharPad || out_character_i == CharMinus
      || (out_character_i >= CharZero && out_character_i <= CharZero + 8'd9))
    else $error("illegal character code");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_last_i      (out_o.last)
);
